FILE: src/sbl_pkg.sv
package sbl_pkg;

	localparam int NUM_BANDS = 5;
	localparam int BIN_COUNT = 128;
	localparam int CNT_W     = $clog2(BIN_COUNT + 1);
	localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
	localparam int BAND_W    = 3;

	typedef logic [NUM_BANDS-1:0][15:0] bounds_t;
	typedef logic [NUM_BANDS-1:0][7:0]  peaks_t;

	localparam bounds_t BOUNDS_RESET = {16'd32808, 16'd10256, 16'd4104, 16'd2052, 16'd1026};
	localparam logic [7:0] FLOOR_RESET = 8'd70;
	localparam logic [7:0] TOP_RESET   = 8'd170;

	// register indexes
	localparam logic [2:0] CFG_BAND0     = 3'd0;
	localparam logic [2:0] CFG_BAND1     = 3'd1;
	localparam logic [2:0] CFG_BAND2     = 3'd2;
	localparam logic [2:0] CFG_BAND3     = 3'd3;
	localparam logic [2:0] CFG_BAND4     = 3'd4;
	localparam logic [2:0] CFG_FLOOR_MIN = 3'd5;
	localparam logic [2:0] CFG_MAP_TOP   = 3'd6;

	// constant factors
	localparam logic [15:0] SCALE0_MUL = 16'd85;
	localparam logic [15:0] SCALE1_MUL = 16'd95;
	localparam logic [7:0]  SCALE_DIV  = 8'd100;
	localparam logic [15:0] FLOOR_MUL  = 16'd19;
	localparam logic [7:0]  FLOOR_DIV  = 8'd20;
	localparam logic [7:0]  LEVEL_MAX  = 8'd255;

	// divider request and response, quotient must fit in 8 bits
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [7:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quot;
	} div_rsp_t;

endpackage

FILE: src/spectrum_band_level_adaptive_floor_core.sv
// Band level meter: a bin word is taken while start is high and busy is low, and the five
// band maxima are kept on the fly. The bin flagged last_bin raises busy; the block then
// scales bands 0 and 1, maps each band to a level against the adaptive noise floor and
// puts out five level words on consecutive strobes of result_valid, then updates the
// floor. All divisions share one 8-step restoring divider, so how long the end of a
// frame keeps busy high depends on how many bands need a mapping division.
// result_valid lasts one cycle and cannot be held off, so the receiver must take
// every level word when it appears. Configuration writes are always ready and belong
// in the idle time between frames.
module spectrum_band_level_adaptive_floor_core
	import sbl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        magnitude,
	input  logic              last_bin,
	output logic              result_valid,
	output logic [BAND_W-1:0] band_number,
	output logic [7:0]        level,
	output logic              last_band,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_MAP   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_FLOOR = 3'd6;

	logic [2:0]        state_q;
	logic [BAND_W-1:0] band_q;
	logic [7:0]        p_q;
	logic [7:0]        lvl_q;
	logic [7:0]        min_q;
	logic              have_min_q;
	logic [7:0]        floor_q;
	bounds_t           bounds_q;
	logic [7:0]        floor_min_q;
	logic [7:0]        top_q;

	logic        accept;
	logic [7:0]  rd_peak;
	logic        clear;
	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic [7:0]  p_diff;
	logic [15:0] map_num;
	logic [15:0] floor_num;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign p_diff    = p_q - floor_q;
	assign map_num   = {p_diff, 8'd0} - {8'd0, p_diff};
	assign floor_num = 16'(floor_q) * FLOOR_MUL + {8'd0, (have_min_q ? min_q : 8'd0)};
	assign clear     = (state_q == ST_FLOOR) && div_rsp.done;

	sbl_peaks u_peaks (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.magnitude (magnitude),
		.last_bin  (last_bin),
		.bounds    (bounds_q),
		.clear     (clear),
		.rd_band   (band_q),
		.rd_peak   (rd_peak)
	);

	sbl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// divider operands per sequencer step
	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_FETCH: begin
				if (band_q == BAND_W'(0)) begin
					div_req.start    = 1'b1;
					div_req.dividend = 16'(rd_peak) * SCALE0_MUL;
					div_req.divisor  = SCALE_DIV;
				end else if (band_q == BAND_W'(1)) begin
					div_req.start    = 1'b1;
					div_req.dividend = 16'(rd_peak) * SCALE1_MUL;
					div_req.divisor  = SCALE_DIV;
				end
			end
			ST_EVAL: begin
				div_req.start    = (p_q >= floor_q) && (floor_q < top_q) && (p_q < top_q);
				div_req.dividend = map_num;
				div_req.divisor  = top_q - floor_q;
			end
			ST_MAP: begin
				div_req.dividend = map_num;
				div_req.divisor  = top_q - floor_q;
			end
			ST_EMIT: begin
				div_req.start    = (band_q == BAND_W'(NUM_BANDS - 1));
				div_req.dividend = floor_num;
				div_req.divisor  = FLOOR_DIV;
			end
			ST_SCALE: begin
				div_req.dividend = '0;
				div_req.divisor  = SCALE_DIV;
			end
			ST_FLOOR: begin
				div_req.dividend = floor_num;
				div_req.divisor  = FLOOR_DIV;
			end
			default: div_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			band_q      <= '0;
			have_min_q  <= 1'b0;
			floor_q     <= FLOOR_RESET;
			bounds_q    <= BOUNDS_RESET;
			floor_min_q <= FLOOR_RESET;
			top_q       <= TOP_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index) inside
					CFG_BAND0, CFG_BAND1, CFG_BAND2, CFG_BAND3, CFG_BAND4:
						bounds_q[cfg_index] <= cfg_data;
					CFG_FLOOR_MIN: floor_min_q <= cfg_data[7:0];
					CFG_MAP_TOP:   top_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && last_bin) begin
						state_q    <= ST_FETCH;
						band_q     <= '0;
						have_min_q <= 1'b0;
					end
				end
				ST_FETCH: begin
					if (band_q == BAND_W'(0) || band_q == BAND_W'(1)) begin
						state_q <= ST_SCALE;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_SCALE: begin
					if (div_rsp.done) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (p_q < floor_q) begin
						state_q <= ST_EMIT;
					end else begin
						if (!have_min_q || p_q < min_q) begin
							have_min_q <= 1'b1;
						end
						if (floor_q >= top_q || p_q >= top_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MAP;
						end
					end
				end
				ST_MAP: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (band_q == BAND_W'(NUM_BANDS - 1)) begin
						state_q <= ST_FLOOR;
					end else begin
						band_q  <= band_q + BAND_W'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_FLOOR: begin
					if (div_rsp.done) begin
						floor_q <= (div_rsp.quot < floor_min_q) ? floor_min_q : div_rsp.quot;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_FETCH: p_q <= rd_peak;
			ST_SCALE: begin
				if (div_rsp.done) begin
					p_q <= div_rsp.quot;
				end
			end
			ST_EVAL: begin
				if (p_q < floor_q) begin
					lvl_q <= '0;
				end else begin
					if (!have_min_q || p_q < min_q) begin
						min_q <= p_q;
					end
					lvl_q <= LEVEL_MAX;
				end
			end
			ST_MAP: begin
				if (div_rsp.done) begin
					lvl_q <= div_rsp.quot;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = (state_q == ST_EMIT);
	assign band_number  = band_q;
	assign level        = lvl_q;
	assign last_band    = (band_q == BAND_W'(NUM_BANDS - 1));

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe outside a frame end");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_bin) |=> (busy && band_number == BAND_W'(0)))
		else $error("last bin did not start band processing");

	a_floor_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_band) |=> (busy && !result_valid))
		else $error("floor update did not follow the last band");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (band_number <= BAND_W'(NUM_BANDS - 1)))
		else $error("band number out of range");

endmodule

FILE: src/sbl_div.sv
module sbl_div
	import sbl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic       run_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] rem_q;
	logic [7:0] sh_q;
	logic [8:0] trial;
	logic       qbit;
	logic [8:0] diff;

	assign trial = {rem_q, sh_q[7]};
	assign qbit  = (trial >= {1'b0, req.divisor});
	assign diff  = trial - {1'b0, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[15:8];
			sh_q  <= req.dividend[7:0];
		end else if (run_q) begin
			rem_q <= qbit ? diff[7:0] : trial[7:0];
			sh_q  <= {sh_q[6:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

endmodule

FILE: src/sbl_peaks.sv
module sbl_peaks
	import sbl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        magnitude,
	input  logic              last_bin,
	input  bounds_t           bounds,
	input  logic              clear,
	input  logic [BAND_W-1:0] rd_band,
	output logic [7:0]        rd_peak
);

	logic [CNT_W-1:0] bin_cnt_q;
	peaks_t           peak_q;
	logic [CMP_W-1:0] pos;

	assign pos = CMP_W'(bin_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q <= '0;
			peak_q    <= '0;
		end else begin
			if (clear) begin
				peak_q <= '0;
			end else if (accept && (bin_cnt_q < CNT_W'(BIN_COUNT))) begin
				for (int k = 0; k < NUM_BANDS; k++) begin
					if ((pos >= CMP_W'(bounds[k][6:0])) && (pos < CMP_W'(bounds[k][15:8]))
					    && (magnitude > peak_q[k])) begin
						peak_q[k] <= magnitude;
					end
				end
			end
			if (accept) begin
				if (last_bin) begin
					bin_cnt_q <= '0;
				end else if (bin_cnt_q < CNT_W'(BIN_COUNT)) begin
					bin_cnt_q <= bin_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	assign rd_peak = peak_q[rd_band];

endmodule
